// ===== sv/sdc_pkg.sv =====
// Shared package for the soft dynamics chain: fixed-point formats, register
// widths and reset values, configuration register indexes, configuration struct.
// No dependencies.
`default_nettype none

package sdc_pkg;

    localparam int FRAC_BITS        = 20;
    localparam int MAX_STAGES_DEF   = 16;
    localparam int SAMPLE_BITS_DEF  = 24;

    localparam int EPS_W    = 20;
    localparam int THR_W    = 23;
    localparam int RATIO_W  = 24;
    localparam int SLOPE_W  = 22;
    localparam int GAIN_W   = 22;
    localparam int COUNT_W  = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [EPS_W-1:0]   EPS_RST   = EPS_W'(2621);
    localparam logic [THR_W-1:0]   THR_RST   = THR_W'(524288);
    localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(2097152);
    localparam logic [SLOPE_W-1:0] SLOPE_RST = SLOPE_W'(524288);
    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(1153434);
    localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GATE_EPS   = 3'd0,
        CFG_KNEE_THR   = 3'd1,
        CFG_RATIO      = 3'd2,
        CFG_SAT_SLOPE  = 3'd3,
        CFG_GAIN       = 3'd4,
        CFG_STAGE_CNT  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [EPS_W-1:0]   gate_eps;
        logic [THR_W-1:0]   knee_thr;
        logic [RATIO_W-1:0] ratio;
        logic [SLOPE_W-1:0] slope;
        logic [GAIN_W-1:0]  gain;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/sdc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// Uses no package; instantiated by sdc_cell.
`default_nettype none

module sdc_div #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 29,
    parameter int Q_W   = 24,
    parameter int SB_W  = 25
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [SB_W-1:0]  i_side,
    output logic                  o_valid,
    output logic [Q_W-1:0]        o_quo,
    output logic [SB_W-1:0]       o_side
);

    logic             r_valid [0:Q_W-1];
    logic [DEN_W-1:0] r_rem   [0:Q_W-1];
    logic [DEN_W-1:0] r_den   [0:Q_W-1];
    logic [Q_W-1:0]   r_quo   [0:Q_W-1];
    logic [Q_W-1:0]   r_low   [0:Q_W-1];
    logic [SB_W-1:0]  r_side  [0:Q_W-1];

    logic             w_valid [0:Q_W-1];
    logic [DEN_W-1:0] w_rem   [0:Q_W-1];
    logic [DEN_W-1:0] w_den   [0:Q_W-1];
    logic [Q_W-1:0]   w_quo   [0:Q_W-1];
    logic [Q_W-1:0]   w_low   [0:Q_W-1];
    logic [SB_W-1:0]  w_side  [0:Q_W-1];
    logic [DEN_W:0]   w_trial [0:Q_W-1];
    logic [DEN_W:0]   w_diff  [0:Q_W-1];
    logic             w_ge    [0:Q_W-1];
    logic [DEN_W-1:0] n_rem   [0:Q_W-1];
    logic [Q_W-1:0]   n_quo   [0:Q_W-1];

    always_comb begin
        for (int k = 0; k < Q_W; k++) begin
            if (k == 0) begin
                w_valid[k] = i_valid;
                w_rem[k]   = DEN_W'(i_num >> Q_W);
                w_den[k]   = i_den;
                w_quo[k]   = '0;
                w_low[k]   = i_num[Q_W-1:0];
                w_side[k]  = i_side;
            end else begin
                w_valid[k] = r_valid[k-1];
                w_rem[k]   = r_rem[k-1];
                w_den[k]   = r_den[k-1];
                w_quo[k]   = r_quo[k-1];
                w_low[k]   = r_low[k-1];
                w_side[k]  = r_side[k-1];
            end
            w_trial[k] = {w_rem[k], w_low[k][Q_W-1-k]};
            w_diff[k]  = w_trial[k] - {1'b0, w_den[k]};
            w_ge[k]    = (w_trial[k] >= {1'b0, w_den[k]});
            n_rem[k]   = w_ge[k] ? w_diff[k][DEN_W-1:0] : w_trial[k][DEN_W-1:0];
            n_quo[k]   = {w_quo[k][Q_W-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Q_W; k++) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid[k];
            end
            if (i_en) begin
                r_rem[k]  <= n_rem[k];
                r_den[k]  <= w_den[k];
                r_quo[k]  <= n_quo[k];
                r_low[k]  <= w_low[k];
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_valid = r_valid[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

`default_nettype wire

// ===== sv/sdc_cell.sv =====
// One effect stage of the chain: soft gate, soft knee, soft saturation, gain, clamp.
// Depends on sdc_pkg and sdc_div.
`default_nettype none

module sdc_cell #(
    parameter int MW = sdc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire sdc_pkg::t_cfg i_cfg,
    input  wire logic          i_active,
    input  wire logic          i_valid,
    input  wire logic [MW-1:0] i_mag,
    input  wire logic          i_neg,
    output logic               o_valid,
    output logic [MW-1:0]      o_mag,
    output logic               o_neg
);

    localparam int F     = sdc_pkg::FRAC_BITS;
    localparam int SQ_W  = 2*MW - F;
    localparam int D1_W  = (SQ_W > sdc_pkg::EPS_W ? SQ_W : sdc_pkg::EPS_W) + 1;
    localparam int Q1_W  = F + 1;
    localparam int P_W   = MW + sdc_pkg::RATIO_W - F;
    localparam int D2_W  = P_W + 1;
    localparam int S_W   = MW + sdc_pkg::SLOPE_W - F;
    localparam int D3_W  = S_W + 1;
    localparam int G_W   = MW + sdc_pkg::GAIN_W - F;
    localparam int OV_W  = (MW > sdc_pkg::THR_W ? MW : sdc_pkg::THR_W);
    localparam int SB1_W = MW + 2;
    localparam int SB_W  = MW + 1;

    // square
    logic [2*MW-1:0] w_sq_prod;
    logic            r1_valid, r1_neg;
    logic [MW-1:0]   r1_mag;
    logic [SQ_W-1:0] r1_sq;

    assign w_sq_prod = i_mag * i_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_neg <= i_neg;
            r1_mag <= i_mag;
            r1_sq  <= w_sq_prod[2*MW-1:F];
        end
    end

    // gate factor sq / (sq + eps)
    logic [D1_W-1:0]  w_d1_den;
    logic             w_d1_zero;
    logic             d1_valid;
    logic [Q1_W-1:0]  d1_quo;
    logic [SB1_W-1:0] d1_side;

    assign w_d1_den  = D1_W'(r1_sq) + D1_W'(i_cfg.gate_eps);
    assign w_d1_zero = (w_d1_den == '0);

    sdc_div #(.NUM_W(SQ_W + F), .DEN_W(D1_W), .Q_W(Q1_W), .SB_W(SB1_W)) u_div_gate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r1_valid),
        .i_num   ({r1_sq, F'(0)}),
        .i_den   (w_d1_den),
        .i_side  ({w_d1_zero, r1_neg, r1_mag}),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    // apply gate
    logic [MW+Q1_W-1:0] w_m1_prod;
    logic               r2_valid, r2_neg;
    logic [MW-1:0]      r2_m1, r2_orig;

    assign w_m1_prod = d1_side[MW-1:0] * d1_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= d1_valid;
        end
        if (i_en) begin
            r2_neg  <= d1_side[MW];
            r2_orig <= d1_side[MW-1:0];
            r2_m1   <= d1_side[MW+1] ? '0 : w_m1_prod[F+MW-1:F];
        end
    end

    // amount above knee
    logic [OV_W-1:0] w_m1x, w_thrx;
    logic            r3_valid, r3_neg;
    logic [MW-1:0]   r3_over, r3_m1, r3_orig;

    assign w_m1x  = OV_W'(r2_m1);
    assign w_thrx = OV_W'(i_cfg.knee_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r3_neg  <= r2_neg;
            r3_orig <= r2_orig;
            r3_m1   <= r2_m1;
            r3_over <= (w_m1x > w_thrx) ? MW'(w_m1x - w_thrx) : '0;
        end
    end

    // knee slope
    logic [MW+sdc_pkg::RATIO_W-1:0] w_p_prod;
    logic                           r4_valid, r4_neg;
    logic [P_W-1:0]                 r4_p;
    logic [MW-1:0]                  r4_m1, r4_orig;

    assign w_p_prod = r3_over * i_cfg.ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
        if (i_en) begin
            r4_neg  <= r3_neg;
            r4_orig <= r3_orig;
            r4_m1   <= r3_m1;
            r4_p    <= w_p_prod[MW+sdc_pkg::RATIO_W-1:F];
        end
    end

    // knee division m / (1 + p)
    logic            d2_valid;
    logic [MW-1:0]   d2_quo;
    logic [SB_W-1:0] d2_side;

    sdc_div #(.NUM_W(MW + F), .DEN_W(D2_W), .Q_W(MW), .SB_W(SB_W)) u_div_knee (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r4_valid),
        .i_num   ({r4_m1, F'(0)}),
        .i_den   (D2_W'(r4_p) + (D2_W'(1) << F)),
        .i_side  ({r4_neg, r4_orig}),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    // saturation slope
    logic [MW+sdc_pkg::SLOPE_W-1:0] w_s_prod;
    logic                           r5_valid;
    logic [S_W-1:0]                 r5_s;
    logic [MW-1:0]                  r5_m;
    logic [SB_W-1:0]                r5_side;

    assign w_s_prod = d2_quo * i_cfg.slope;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= d2_valid;
        end
        if (i_en) begin
            r5_side <= d2_side;
            r5_m    <= d2_quo;
            r5_s    <= w_s_prod[MW+sdc_pkg::SLOPE_W-1:F];
        end
    end

    // saturation division m / (1 + s)
    logic            d3_valid;
    logic [MW-1:0]   d3_quo;
    logic [SB_W-1:0] d3_side;

    sdc_div #(.NUM_W(MW + F), .DEN_W(D3_W), .Q_W(MW), .SB_W(SB_W)) u_div_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r5_valid),
        .i_num   ({r5_m, F'(0)}),
        .i_den   (D3_W'(r5_s) + (D3_W'(1) << F)),
        .i_side  (r5_side),
        .o_valid (d3_valid),
        .o_quo   (d3_quo),
        .o_side  (d3_side)
    );

    // gain
    logic [MW+sdc_pkg::GAIN_W-1:0] w_g_prod;
    logic                          r6_valid;
    logic [G_W-1:0]                r6_g;
    logic [SB_W-1:0]               r6_side;

    assign w_g_prod = d3_quo * i_cfg.gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r6_valid <= d3_valid;
        end
        if (i_en) begin
            r6_side <= d3_side;
            r6_g    <= w_g_prod[MW+sdc_pkg::GAIN_W-1:F];
        end
    end

    // clamp to format; bypass when stage is not in use
    logic [G_W-1:0] w_lim, w_sat;
    logic           r7_valid, r7_neg;
    logic [MW-1:0]  r7_mag;

    assign w_lim = (G_W'(1) << (MW-1)) - G_W'(!r6_side[MW]);
    assign w_sat = (r6_g > w_lim) ? w_lim : r6_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (i_en) begin
            r7_valid <= r6_valid;
        end
        if (i_en) begin
            r7_neg <= r6_side[MW];
            r7_mag <= i_active ? w_sat[MW-1:0] : r6_side[MW-1:0];
        end
    end

    assign o_valid = r7_valid;
    assign o_mag   = r7_mag;
    assign o_neg   = r7_neg;

endmodule

`default_nettype wire

// ===== sv/soft_dynamics_chain_core.sv =====
// Soft dynamics chain top level: MAX_STAGES effect cells in a row.
// Each cell holds three bit-per-stage dividers. Throughput: one transaction per cycle
// unless the consumer stalls a finished result held in the output register.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
// Depends on sdc_pkg, sdc_cell, sdc_div.
`default_nettype none

module soft_dynamics_chain_core #(
    parameter int MAX_STAGES  = sdc_pkg::MAX_STAGES_DEF,
    parameter int SAMPLE_BITS = sdc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // sample input channel
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_sample_in,
    // sample output channel
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [SAMPLE_BITS-1:0]           o_sample_out,
    // configuration write port
    input  wire logic                               i_cfg_we,
    input  wire logic [sdc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [sdc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int MW = SAMPLE_BITS;

    // Configuration registers. Writes beyond the list are dropped.
    sdc_pkg::t_cfg                r_cfg;
    logic [sdc_pkg::COUNT_W-1:0]  r_stage_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_eps <= sdc_pkg::EPS_RST;
            r_cfg.knee_thr <= sdc_pkg::THR_RST;
            r_cfg.ratio    <= sdc_pkg::RATIO_RST;
            r_cfg.slope    <= sdc_pkg::SLOPE_RST;
            r_cfg.gain     <= sdc_pkg::GAIN_RST;
            r_stage_count  <= sdc_pkg::COUNT_RST;
        end else if (i_cfg_we) begin
            case (sdc_pkg::t_cfg_idx'(i_cfg_idx))
                sdc_pkg::CFG_GATE_EPS:  r_cfg.gate_eps <= i_cfg_data[sdc_pkg::EPS_W-1:0];
                sdc_pkg::CFG_KNEE_THR:  r_cfg.knee_thr <= i_cfg_data[sdc_pkg::THR_W-1:0];
                sdc_pkg::CFG_RATIO:     r_cfg.ratio    <= i_cfg_data[sdc_pkg::RATIO_W-1:0];
                sdc_pkg::CFG_SAT_SLOPE: r_cfg.slope    <= i_cfg_data[sdc_pkg::SLOPE_W-1:0];
                sdc_pkg::CFG_GAIN:      r_cfg.gain     <= i_cfg_data[sdc_pkg::GAIN_W-1:0];
                sdc_pkg::CFG_STAGE_CNT: r_stage_count  <= i_cfg_data[sdc_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Output register, filled at the end of the row of cells.
    logic          r_out_valid;
    logic [MW-1:0] r_out_data;

    // The whole chain advances together; it only holds while a finished
    // result sits in the output register and the consumer stalls.
    logic w_en;
    assign w_en    = !r_out_valid || !i_stall;
    assign o_stall = !w_en;

    // Front end: split the sample into sign and magnitude.
    // The most negative code maps to magnitude 2^(MW-1), which still fits.
    logic [MW-1:0] w_raw, w_in_mag;
    logic          w_in_neg;
    logic          r_in_valid, r_in_neg;
    logic [MW-1:0] r_in_mag;

    assign w_raw    = i_sample_in;
    assign w_in_neg = w_raw[MW-1];
    assign w_in_mag = w_in_neg ? (~w_raw + 1'b1) : w_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_en) begin
            r_in_valid <= i_valid;
        end
        if (w_en) begin
            r_in_mag <= w_in_mag;
            r_in_neg <= w_in_neg;
        end
    end

    // Row of cells. Cells at or past stage_count pass the magnitude through
    // with the same latency; counts above MAX_STAGES simply use every cell.
    logic          w_valid  [0:MAX_STAGES];
    logic [MW-1:0] w_mag    [0:MAX_STAGES];
    logic          w_neg    [0:MAX_STAGES];
    logic          w_active [0:MAX_STAGES-1];

    assign w_valid[0] = r_in_valid;
    assign w_mag[0]   = r_in_mag;
    assign w_neg[0]   = r_in_neg;

    for (genvar k = 0; k < MAX_STAGES; k++) begin : g_cell
        assign w_active[k] = (32'(k) < 32'(r_stage_count));

        sdc_cell #(.MW(MW)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_cfg    (r_cfg),
            .i_active (w_active[k]),
            .i_valid  (w_valid[k]),
            .i_mag    (w_mag[k]),
            .i_neg    (w_neg[k]),
            .o_valid  (w_valid[k+1]),
            .o_mag    (w_mag[k+1]),
            .o_neg    (w_neg[k+1])
        );
    end

    // Output register: restore the sign.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_valid[MAX_STAGES];
        end
        if (w_en) begin
            r_out_data <= w_neg[MAX_STAGES] ? (~w_mag[MAX_STAGES] + 1'b1)
                                            : w_mag[MAX_STAGES];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_out_data;

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !w_valid[MAX_STAGES]) |=> !o_valid)
        else $error("result repeated after delivery");
`endif

endmodule

`default_nettype wire
